[rtl/pvu_pkg.sv]
// Shared types and constants for the particle swarm velocity update core.
package pvu_pkg;

    localparam int NUM_PARTICLES = 64;
    localparam int IDX_W         = 6;

    // Configuration register indexes
    localparam logic [1:0] REG_INERTIA   = 2'd0;
    localparam logic [1:0] REG_COGNITIVE = 2'd1;
    localparam logic [1:0] REG_SOCIAL    = 2'd2;

    // Multiply sequence steps
    localparam logic [3:0] OP_GAIN_C = 4'd0;
    localparam logic [3:0] OP_GAIN_S = 4'd1;
    localparam logic [3:0] OP_INER_X = 4'd2;
    localparam logic [3:0] OP_COG_X  = 4'd3;
    localparam logic [3:0] OP_SOC_X  = 4'd4;
    localparam logic [3:0] OP_INER_Y = 4'd5;
    localparam logic [3:0] OP_COG_Y  = 4'd6;
    localparam logic [3:0] OP_SOC_Y  = 4'd7;
    localparam logic [3:0] OP_SQ_X   = 4'd8;
    localparam logic [3:0] OP_SQ_Y   = 4'd9;
    localparam logic [3:0] OP_SQ_LIM = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SQRT,
        ST_SCALE,
        ST_DIV,
        ST_FIN
    } state_t;

    // One personal best entry
    typedef struct packed {
        logic [15:0]        score;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pbest_t;

endpackage

[rtl/pso_velocity_update_core.sv]
// Particle swarm velocity update core with a shared multiplier, square root and divider.
//
// One particle update is taken per transfer and one velocity result is returned for it.
// The work runs through one shared 33x33 multiplier under a sequencer: 11 multiplies, then,
// only when the magnitude exceeds the speed limit, a 32-step square root and for each axis
// one multiply and a 31-step restoring divide. An item runs through accept, personal best
// read, the multiplies and the output load, and when clamped also the square root and the
// divides. The input is not ready while an item is in work, and the output load waits while
// an earlier result still sits in the output register; a loaded result waits there while
// the next item is accepted. Personal bests live in a 64-entry memory guarded by
// per-particle seen bits cleared at reset, so no clearing pass is needed.
module pso_velocity_update_core (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: particle_index[5:0], pos_x[37:6], pos_y[69:38], vel_x[101:70],
    //          vel_y[133:102], score[149:134], rand_cognitive[165:150],
    //          rand_social[181:166], speed_limit[212:182], zero[215:213]
    input  logic [215:0] s_tdata,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: new_vel_x[31:0], new_vel_y[63:32]
    output logic [63:0]  m_tdata
);
    import pvu_pkg::*;

    // Configuration
    logic [15:0] inertia_reg, cog_reg, soc_reg;

    // Captured item
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [15:0]        sc_reg, rc_reg, rs_reg;
    logic [30:0]        lim_reg;

    // Stores
    pbest_t                   pmem [NUM_PARTICLES];
    pbest_t                   rd_reg;
    logic [NUM_PARTICLES-1:0] seen_reg;
    logic [15:0]              gscore_reg;
    logic signed [31:0]       gx_reg, gy_reg;

    // Datapath
    logic signed [32:0] dpx_reg, dpy_reg, dgx_reg, dgy_reg;
    logic [15:0]        fc_reg, fs_reg;
    logic signed [38:0] accx_reg, accy_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic [63:0]        m2_reg;
    logic [63:0]        n_reg, root_reg, bit_reg;
    logic [31:0]        mag_reg;
    logic [31:0]        rem_reg;
    logic [30:0]        dvd_reg, quot_reg;
    logic [4:0]         dcnt_reg;
    logic               axis_reg;
    logic [3:0]         op_reg;
    logic               phase_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [38:0] prod_sh;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic [63:0] out_data_reg;

    logic in_fire, fin_load;
    logic replace_p, replace_g, mem_we;
    logic [31:0] abs_v;
    logic        neg_v;
    logic [32:0] div_t;
    logic        div_ge;
    logic [30:0] quot_next;
    logic [63:0] sq_t;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] a);
        if (a > 39'sd2147483647)       return 32'sh7FFFFFFF;
        else if (a < -39'sd2147483648) return 32'sh80000000;
        else                           return a[31:0];
    endfunction

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // Best replacement decisions
    assign replace_p = !seen_reg[idx_reg] || (sc_reg > rd_reg.score);
    assign replace_g = sc_reg > gscore_reg;
    assign mem_we    = (state_reg == ST_LOAD) && replace_p;

    // Scaling operands for the current axis
    assign neg_v = axis_reg ? ny_reg[31] : nx_reg[31];
    assign abs_v = axis_reg ? (ny_reg[31] ? 32'(-ny_reg) : ny_reg)
                            : (nx_reg[31] ? 32'(-nx_reg) : nx_reg);

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SCALE) begin
            mul_a = {1'b0, abs_v};
            mul_b = {2'b00, lim_reg};
        end else begin
            unique case (op_reg)
                OP_GAIN_C: begin mul_a = {17'd0, cog_reg}; mul_b = {17'd0, rc_reg}; end
                OP_GAIN_S: begin mul_a = {17'd0, soc_reg}; mul_b = {17'd0, rs_reg}; end
                OP_INER_X: begin mul_a = 33'(vx_reg); mul_b = {17'd0, inertia_reg}; end
                OP_COG_X:  begin mul_a = dpx_reg; mul_b = {17'd0, fc_reg}; end
                OP_SOC_X:  begin mul_a = dgx_reg; mul_b = {17'd0, fs_reg}; end
                OP_INER_Y: begin mul_a = 33'(vy_reg); mul_b = {17'd0, inertia_reg}; end
                OP_COG_Y:  begin mul_a = dpy_reg; mul_b = {17'd0, fc_reg}; end
                OP_SOC_Y:  begin mul_a = dgy_reg; mul_b = {17'd0, fs_reg}; end
                OP_SQ_X:   begin mul_a = 33'(nx_reg); mul_b = 33'(nx_reg); end
                OP_SQ_Y:   begin mul_a = 33'(ny_reg); mul_b = 33'(ny_reg); end
                OP_SQ_LIM: begin mul_a = {2'b00, lim_reg}; mul_b = {2'b00, lim_reg}; end
                default:   begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod_sh = signed'(prod_reg[50:12]);

    // Divider and square root step logic
    assign div_t     = {rem_reg, dvd_reg[30]};
    assign div_ge    = div_t >= {1'b0, mag_reg};
    assign quot_next = {quot_reg[29:0], div_ge};
    assign sq_t      = root_reg + bit_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL: begin
                if (phase_reg && op_reg == OP_SQ_LIM) begin
                    state_next = (m2_reg > 64'(prod_reg)) ? ST_SQRT : ST_FIN;
                end
            end
            ST_SQRT:  if (bit_reg == '0) state_next = ST_SCALE;
            ST_SCALE: if (phase_reg) state_next = ST_DIV;
            ST_DIV:   if (dcnt_reg == 5'd30) state_next = axis_reg ? ST_FIN : ST_SCALE;
            ST_FIN:   if (fin_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inertia_reg <= 16'd4096;
            cog_reg     <= 16'd6144;
            soc_reg     <= 16'd6144;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_INERTIA:   inertia_reg <= cfg_wdata;
                REG_COGNITIVE: cog_reg     <= cfg_wdata;
                REG_SOCIAL:    soc_reg     <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Personal best memory
    always_ff @(posedge aclk) begin
        if (mem_we) pmem[idx_reg] <= '{score: sc_reg, x: px_reg, y: py_reg};
        if (in_fire) rd_reg <= pmem[s_tdata[5:0]];
    end

    // Seen bits and global best
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= '0;
            gscore_reg <= '0;
            gx_reg     <= '0;
            gy_reg     <= '0;
        end else if (state_reg == ST_LOAD) begin
            seen_reg[idx_reg] <= 1'b1;
            if (replace_g) begin
                gscore_reg <= sc_reg;
                gx_reg     <= px_reg;
                gy_reg     <= py_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn)      out_valid_reg <= 1'b0;
        else if (fin_load) out_valid_reg <= 1'b1;
        else if (m_tready) out_valid_reg <= 1'b0;
        if (fin_load) out_data_reg <= {ny_reg, nx_reg};
    end

    // Shared multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath sequencing
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                op_reg    <= OP_GAIN_C;
                phase_reg <= 1'b0;
                axis_reg  <= 1'b0;
                if (in_fire) begin
                    idx_reg <= s_tdata[5:0];
                    px_reg  <= s_tdata[37:6];
                    py_reg  <= s_tdata[69:38];
                    vx_reg  <= s_tdata[101:70];
                    vy_reg  <= s_tdata[133:102];
                    sc_reg  <= s_tdata[149:134];
                    rc_reg  <= s_tdata[165:150];
                    rs_reg  <= s_tdata[181:166];
                    lim_reg <= s_tdata[212:182];
                end
            end
            ST_LOAD: begin
                // Pull differences against the updated bests
                dpx_reg <= replace_p ? '0 : 33'(rd_reg.x) - 33'(px_reg);
                dpy_reg <= replace_p ? '0 : 33'(rd_reg.y) - 33'(py_reg);
                dgx_reg <= replace_g ? '0 : 33'(gx_reg) - 33'(px_reg);
                dgy_reg <= replace_g ? '0 : 33'(gy_reg) - 33'(py_reg);
            end
            ST_MUL: begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    op_reg <= op_reg + 4'd1;
                    unique case (op_reg)
                        OP_GAIN_C: fc_reg <= prod_reg[31:16];
                        OP_GAIN_S: fs_reg <= prod_reg[31:16];
                        OP_INER_X: accx_reg <= prod_sh;
                        OP_COG_X:  accx_reg <= accx_reg + prod_sh;
                        OP_SOC_X:  accx_reg <= accx_reg + prod_sh;
                        OP_INER_Y: accy_reg <= prod_sh;
                        OP_COG_Y:  accy_reg <= accy_reg + prod_sh;
                        OP_SOC_Y: begin
                            nx_reg <= sat32(accx_reg);
                            ny_reg <= sat32(accy_reg + prod_sh);
                        end
                        OP_SQ_X:   m2_reg <= 64'(prod_reg);
                        OP_SQ_Y:   m2_reg <= m2_reg + 64'(prod_reg);
                        OP_SQ_LIM: begin
                            n_reg    <= m2_reg;
                            root_reg <= '0;
                            bit_reg  <= 64'd1 << 62;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQRT: begin
                // One root bit per cycle
                if (bit_reg != '0) begin
                    if (n_reg >= sq_t) begin
                        n_reg    <= n_reg - sq_t;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end else begin
                    mag_reg <= root_reg[31:0];
                end
            end
            ST_SCALE: begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    rem_reg  <= {1'b0, prod_reg[61:31]};
                    dvd_reg  <= prod_reg[30:0];
                    quot_reg <= '0;
                    dcnt_reg <= '0;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle
                rem_reg  <= div_ge ? 32'(div_t - {1'b0, mag_reg}) : div_t[31:0];
                dvd_reg  <= {dvd_reg[29:0], 1'b0};
                quot_reg <= quot_next;
                dcnt_reg <= dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd30) begin
                    axis_reg <= 1'b1;
                    if (axis_reg) ny_reg <= neg_v ? -signed'({1'b0, quot_next}) : {1'b0, quot_next};
                    else          nx_reg <= neg_v ? -signed'({1'b0, quot_next}) : {1'b0, quot_next};
                end
            end
            ST_FIN: ;
            default: ;
        endcase
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted again while an item is in work");

    a_sqrt_bit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> $onehot0(bit_reg))
        else $error("square root bit register is not one-hot");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < mag_reg))
        else $error("divider remainder not below the magnitude");

    a_result_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_load |=> out_valid_reg)
        else $error("finished result not presented");

endmodule
